@@ hw/rtl/bpsr_pkg.sv @@
package bpsr_pkg;

    // Window geometry
    localparam int WIN_LEN  = 9;
    localparam int SEQ_LEN  = WIN_LEN + 1;
    localparam int FILL_W   = 4;
    localparam int IDX_W    = 4;
    localparam int TOTAL_W  = 24;
    localparam int COUNT_BITS_DEFAULT = 24;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);

    typedef logic [0:WIN_LEN-1][7:0] win_t;
    typedef logic [0:SEQ_LEN-1][7:0] seq_t;

    // Instruction patterns and their replacements
    localparam win_t PAT_A = '{8'h64, 8'h48, 8'h8B, 8'h04, 8'h25,
                               8'h00, 8'h00, 8'h00, 8'h00};
    localparam win_t REP_A = '{8'h48, 8'hC7, 8'hC0, 8'h00, 8'h00,
                               8'h00, 8'h00, 8'h90, 8'h90};
    localparam win_t PAT_B = '{8'h64, 8'h48, 8'h8B, 8'h04, 8'h25,
                               8'h28, 8'h00, 8'h00, 8'h00};
    localparam win_t REP_B = '{8'h48, 8'hC7, 8'hC0, 8'hEF, 8'hBE,
                               8'hAD, 8'hDE, 8'h90, 8'h90};

    // One emit job handed from front to back.
    // seq[0] is the byte pushed out of the window, seq[1..9] the window.
    // Bytes seq[first] .. seq[last] are emitted; the last one carries the
    // end mark when flush is set.
    typedef struct packed {
        seq_t               seq;
        logic [IDX_W-1:0]   first;
        logic [IDX_W-1:0]   last;
        logic               flush;
        logic [TOTAL_W-1:0] total;
    } job_t;

endpackage

@@ hw/rtl/byte_pattern_search_replace.sv @@
// Streams a code image byte by byte through a nine-byte window and replaces
// either of two fixed nine-byte instruction sequences with its fixed
// replacement, counting patches (saturating at 2^COUNT_BITS-1, reported on
// the low 24 bits). Once the window holds nine bytes every new byte pushes
// the oldest one out as a result, so in the body of an image one byte enters
// and one leaves per cycle unless input or output stalls. The last byte
// (is_final) flushes the window: up to ten results, one per cycle from the
// output sequencer while result_ready is high, the last flagged end_of_image
// with the final count. A two-deep job queue between the window stage and
// the sequencer lets the next image start entering while a flush drains;
// input stalls only when that queue is full. Images shorter than nine bytes
// pass unchanged. Results pass the job queue and then the output register.
module byte_pattern_search_replace #(
    parameter int COUNT_BITS = bpsr_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         is_final,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [7:0]                   out_byte,
    output logic                         end_of_image,
    output logic [bpsr_pkg::TOTAL_W-1:0] patch_total
);
    import bpsr_pkg::*;

    job_t front_job;
    job_t back_job;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    bpsr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .in_byte    (in_byte),
        .is_final   (is_final),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job        (front_job)
    );

    bpsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    bpsr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .end_of_image (end_of_image),
        .patch_total  (patch_total)
    );

endmodule

@@ hw/rtl/bpsr_front.sv @@
module bpsr_front #(
    parameter int COUNT_BITS = bpsr_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        in_byte,
    input  logic              is_final,
    output logic              job_valid,
    input  logic              job_ready,
    output bpsr_pkg::job_t    job
);
    import bpsr_pkg::*;

    win_t                  win_reg;
    win_t                  win_shift;
    win_t                  win_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_new;
    logic [FILL_W-1:0]     fill_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_bumped;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  full;
    logic                  match_a;
    logic                  match_b;
    logic                  accept;

    assign byte_ready = job_ready;
    assign accept     = byte_valid && byte_ready;
    assign full       = (fill_reg == FILL_FULL);

    // Slide or append the new byte
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (full)
                win_shift[i] = (i == WIN_LEN - 1) ? in_byte : win_reg[(i + 1) % WIN_LEN];
            else if (FILL_W'(i) == fill_reg)
                win_shift[i] = in_byte;
            else
                win_shift[i] = win_reg[i];
        end
    end

    assign fill_new = full ? FILL_FULL : fill_reg + 1'b1;

    // Pattern compare, A has priority
    assign match_a = (fill_new == FILL_FULL) && (win_shift == PAT_A);
    assign match_b = (fill_new == FILL_FULL) && (win_shift == PAT_B);

    always_comb
    begin
        priority if (match_a)
            win_next = REP_A;
        else if (match_b)
            win_next = REP_B;
        else
            win_next = win_shift;
    end

    // Saturating patch counter
    assign cnt_bumped = ((match_a || match_b) && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;

    // Image end clears fill and count
    assign fill_next = is_final ? '0 : fill_new;
    assign cnt_next  = is_final ? '0 : cnt_bumped;

    // Emit job: evicted byte and/or flush of the window
    assign job_valid  = accept && (full || is_final);
    always_comb
    begin
        job.seq[0] = win_reg[0];
        for (int i = 0; i < WIN_LEN; i++)
            job.seq[i + 1] = win_next[i];
        job.first = full ? IDX_W'(0) : IDX_W'(1);
        job.last  = is_final ? IDX_W'(fill_new) : IDX_W'(0);
        job.flush = is_final;
        job.total = TOTAL_W'(cnt_bumped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Window contents, valid only below fill_reg
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

@@ hw/rtl/bpsr_queue.sv @@
module bpsr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bpsr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bpsr_pkg::job_t pop_job
);
    import bpsr_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

@@ hw/rtl/bpsr_back.sv @@
module bpsr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  bpsr_pkg::job_t               job,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [7:0]                   out_byte,
    output logic                         end_of_image,
    output logic [bpsr_pkg::TOTAL_W-1:0] patch_total
);
    import bpsr_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   cur_idx;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         byte_reg;
    logic               end_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               load;
    logic               at_last;

    // Walk the job one byte per cycle into the output register when it is empty or being taken
    assign cur_idx   = busy_reg ? idx_reg : job.first;
    assign at_last   = (cur_idx == job.last);
    assign load      = job_valid && (!out_valid_reg || result_ready);
    assign job_ready = load && at_last;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            busy_next      = !at_last;
            idx_next       = cur_idx + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= job.seq[cur_idx];
            end_reg   <= job.flush && at_last;
            total_reg <= job.total;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = byte_reg;
    assign end_of_image = end_reg;
    assign patch_total  = total_reg;

endmodule

@@ dv/tb_byte_pattern_search_replace.sv @@
module tb_byte_pattern_search_replace;

    // Counter width of the delivered configuration
    localparam int COUNT_W = 24;
    localparam int WIN     = 9;

    // Instruction sequences and their replacements, first byte in the top bits
    localparam logic [71:0] FS_LOAD_0  = 72'h64_48_8B_04_25_00_00_00_00;
    localparam logic [71:0] FS_LOAD_28 = 72'h64_48_8B_04_25_28_00_00_00;
    localparam logic [71:0] MOV_ZERO   = 72'h48_C7_C0_00_00_00_00_90_90;
    localparam logic [71:0] MOV_MAGIC  = 72'h48_C7_C0_EF_BE_AD_DE_90_90;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [23:0] total;
    } image_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       wait_drain;
    } code_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        is_final = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        end_of_image;
    logic [23:0] patch_total;

    byte_pattern_search_replace #(
        .COUNT_BITS(COUNT_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .in_byte      (in_byte),
        .is_final     (is_final),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .end_of_image (end_of_image),
        .patch_total  (patch_total)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    code_req_t   code_q[$];
    image_byte_t patched_q[$];
    logic [7:0]  img_bytes[$];

    // Shadow copy of the window and patch count
    logic [7:0]         win_shadow [0:WIN-1];
    int                 win_fill = 0;
    logic [COUNT_W-1:0] patch_cnt = '0;

    int  errors = 0;
    int  bytes_sent = 0;
    int  images_sent = 0;
    int  patches_seen = 0;
    int  bytes_checked = 0;
    bit  calm = 1'b0;
    int  cyc = 0;

    function automatic logic [7:0] seq_byte(input logic [71:0] s, input int i);
        return s[71-8*i -: 8];
    endfunction

    // Mostly short idles, a few long ones, none during calm stretches
    function automatic int pick_idle(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_patched(input logic [7:0] b, input logic last);
        image_byte_t e;
        e.data  = b;
        e.last  = last;
        e.total = 24'(patch_cnt);
        patched_q.push_back(e);
    endtask

    // Advance the window by one accepted byte and queue the bytes it releases
    task automatic patch_window(input logic [7:0] b, input logic fin);
        logic [7:0]  oldest;
        logic        have_old;
        logic [71:0] cur;
        int          i;
        have_old = 1'b0;
        oldest   = 8'h00;
        cur      = '0;
        if (win_fill == WIN) begin
            oldest   = win_shadow[0];
            have_old = 1'b1;
            for (i = 0; i < WIN - 1; i++)
                win_shadow[i] = win_shadow[i+1];
            win_fill = WIN - 1;
        end
        win_shadow[win_fill] = b;
        win_fill++;

        // Compare only a full window; first sequence wins
        if (win_fill == WIN) begin
            for (i = 0; i < WIN; i++)
                cur[71-8*i -: 8] = win_shadow[i];
            if (cur == FS_LOAD_0 || cur == FS_LOAD_28) begin
                for (i = 0; i < WIN; i++)
                    win_shadow[i] = (cur == FS_LOAD_0) ? seq_byte(MOV_ZERO, i)
                                                      : seq_byte(MOV_MAGIC, i);
                if (patch_cnt != {COUNT_W{1'b1}})
                    patch_cnt++;
                patches_seen++;
            end
        end

        if (have_old)
            push_patched(oldest, 1'b0);

        // Flush on the last byte, then start a fresh image
        if (fin) begin
            for (i = 0; i < win_fill; i++)
                push_patched(win_shadow[i], (i == win_fill - 1));
            win_fill  = 0;
            patch_cnt = '0;
            images_sent++;
        end
    endtask

    // Stimulus building
    task automatic add_seq(input logic [71:0] s);
        int i;
        for (i = 0; i < WIN; i++)
            img_bytes.push_back(seq_byte(s, i));
    endtask

    task automatic commit_image(input bit drain);
        code_req_t r;
        int        i;
        for (i = 0; i < img_bytes.size(); i++) begin
            r.data       = img_bytes[i];
            r.last       = (i == img_bytes.size() - 1);
            r.wait_drain = drain && (i == 0);
            code_q.push_back(r);
        end
        img_bytes.delete();
    endtask

    task automatic add_chunk();
        logic [71:0] s;
        int          kind;
        int          n;
        int          i;
        kind = $urandom_range(0, 9);
        s    = $urandom_range(0, 1) ? FS_LOAD_28 : FS_LOAD_0;
        if (kind < 3) begin
            // plain code bytes
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                img_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 7) begin
            add_seq(s);
        end else if (kind < 9) begin
            // near miss: one byte corrupted
            n = $urandom_range(0, WIN - 1);
            s[71-8*n -: 8] = s[71-8*n -: 8] ^ 8'($urandom_range(1, 255));
            add_seq(s);
        end else begin
            // truncated sequence
            n = $urandom_range(1, WIN - 1);
            for (i = 0; i < n; i++)
                img_bytes.push_back(seq_byte(s, i));
        end
    endtask

    task automatic build_stimulus();
        int i;
        int n;
        int random_bytes;
        bit first;
        bit long_done;

        // Whole image is exactly the first sequence: final position match
        add_seq(FS_LOAD_0);
        commit_image(1'b0);
        // Short images pass through untouched
        img_bytes.push_back(8'h00);
        img_bytes.push_back(8'hFF);
        img_bytes.push_back(8'h64);
        commit_image(1'b0);
        img_bytes.push_back(8'hFF);
        commit_image(1'b0);
        // Second sequence mid-image with bytes pushed out on both sides
        img_bytes.push_back(8'hFF);
        add_seq(FS_LOAD_28);
        img_bytes.push_back(8'h80);
        commit_image(1'b0);

        // Random images built from sequences, near misses and noise
        random_bytes = 0;
        first        = 1'b1;
        long_done    = 1'b0;
        while (random_bytes < 330) begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
                add_chunk();
            random_bytes += img_bytes.size();
            commit_image(first || ($urandom_range(0, 9) == 0));
            first = 1'b0;

            // One longer image of back-to-back sequences
            if (!long_done && random_bytes >= 160) begin
                for (i = 0; i < 6; i++) begin
                    add_seq(i[0] ? FS_LOAD_28 : FS_LOAD_0);
                    if ($urandom_range(0, 7) == 0)
                        img_bytes.push_back(8'($urandom_range(0, 255)));
                end
                commit_image(1'b1);
                long_done = 1'b1;
            end
        end
    endtask

    // Calm stretches with no idling on either side
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc[7:0] == 8'd0)
            calm <= ($urandom_range(0, 2) == 0);
    end

    // Request driver
    int gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_valid <= 1'b0;
            in_byte    <= 8'h00;
            is_final   <= 1'b0;
            gap        <= 0;
        end else begin
            if (byte_valid && byte_ready) begin
                patch_window(in_byte, is_final);
                bytes_sent++;
            end
            if (!byte_valid || byte_ready) begin
                if (gap > 0) begin
                    gap        <= gap - 1;
                    byte_valid <= 1'b0;
                end else if (code_q.size() != 0 &&
                             !(code_q[0].wait_drain && patched_q.size() != 0)) begin
                    byte_valid <= 1'b1;
                    in_byte    <= code_q[0].data;
                    is_final   <= code_q[0].last;
                    code_q.pop_front();
                    gap        <= pick_idle(calm);
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    int stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        image_byte_t exp_b;
        if (!rst_n) begin
            result_ready <= 1'b0;
            stall        <= 0;
        end else begin
            if (result_valid && result_ready) begin
                if (patched_q.size() == 0) begin
                    $error("unexpected result: out_byte=%02h end_of_image=%0b patch_total=%0d",
                           out_byte, end_of_image, patch_total);
                    errors++;
                end else begin
                    exp_b = patched_q.pop_front();
                    bytes_checked++;
                    if (out_byte !== exp_b.data) begin
                        $error("out_byte: expected %02h, got %02h", exp_b.data, out_byte);
                        errors++;
                    end
                    if (end_of_image !== exp_b.last) begin
                        $error("end_of_image: expected %0b, got %0b",
                               exp_b.last, end_of_image);
                        errors++;
                    end
                    if (patch_total !== exp_b.total) begin
                        $error("patch_total: expected %0d, got %0d",
                               exp_b.total, patch_total);
                        errors++;
                    end
                end
            end
            if (stall > 0) begin
                stall        <= stall - 1;
                result_ready <= 1'b0;
            end else begin
                result_ready <= 1'b1;
                stall        <= pick_idle(calm);
            end
        end
    end

    // Main sequence
    initial
    begin
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (code_q.size() != 0 || byte_valid)
            @(posedge clk);
        while (patched_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Streamed %0d bytes in %0d images; %0d sequences patched, %0d bytes checked",
                 bytes_sent, images_sent, patches_seen, bytes_checked);
        $display("Covered short images, final-position matches, near misses and stalls");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
